// File: rtl/core/cdc_pkg.sv
package cdc_pkg;

  // Command codes carried on the action field.
  localparam logic [2:0] ACT_LOAD = 3'd0;
  localparam logic [2:0] ACT_NEXT = 3'd1;
  localparam logic [2:0] ACT_PREV = 3'd2;
  localparam logic [2:0] ACT_ADD  = 3'd3;
  localparam logic [2:0] ACT_SUB  = 3'd4;

  // Month numbers that matter to the length table.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Leap-year cycle of the Gregorian calendar and its century marks.
  localparam logic [8:0] CYCLE_YEARS = 9'd400;
  localparam logic [8:0] CENTURY_1   = 9'd100;
  localparam logic [8:0] CENTURY_2   = 9'd200;
  localparam logic [8:0] CENTURY_3   = 9'd300;
  localparam logic [8:0] CYCLE_LAST  = 9'd399;

  // Division by 25 as a multiply by 2622 and a right shift by 16. It is exact
  // for dividends below 4096, which covers a year of up to 16 bits divided by 16.
  localparam logic [11:0] RECIP_25    = 12'd2622;
  localparam int          RECIP_SHIFT = 16;

  localparam logic [4:0] LEN_FEB_LEAP = 5'd29;
  localparam logic [4:0] LEN_FEB      = 5'd28;
  localparam logic [4:0] LEN_SHORT    = 5'd30;
  localparam logic [4:0] LEN_LONG     = 5'd31;

  // Leap test from the year's position within the 400-year cycle.
  function automatic logic is_leap(input logic [8:0] y400);
    return (y400[1:0] == 2'b00) && (y400 != CENTURY_1) && (y400 != CENTURY_2) &&
           (y400 != CENTURY_3);
  endfunction

  // Length of a month; codes outside 1 to 12 read as a long month.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/cdc_rem400.sv
module cdc_rem400 import cdc_pkg::*; #(
  parameter int YEAR_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [YEAR_BITS-1:0] value,
  output logic                 done,
  output logic [8:0]           rem
);

  // The year is taken as 16 * x plus a low nibble, so its quotient by 400 is x / 25.
  localparam int XW = YEAR_BITS - 4;
  localparam int PW = XW + 12;
  localparam int QW = YEAR_BITS - 8;

  logic                 stage;
  logic [YEAR_BITS-1:0] held;
  logic [PW-1:0]        prod;
  logic [QW-1:0]        quot;
  logic [YEAR_BITS-1:0] cycle_sum;

  // Quotient by reciprocal multiplication, then the whole cycles it stands for.
  always_comb begin
    prod      = PW'(value[YEAR_BITS-1:4]) * PW'(RECIP_25);
    cycle_sum = YEAR_BITS'(quot) * YEAR_BITS'(CYCLE_YEARS);
  end

  // The quotient is registered first, then the remainder from it; done rises together with the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      done  <= 1'b0;
    end else begin
      stage <= start;
      done  <= stage;
    end
  end

  // Datapath of the remainder unit.
  always_ff @(posedge clk) begin
    if (start) begin
      held <= value;
      quot <= prod[PW-1:RECIP_SHIFT];
    end
    if (stage) begin
      rem <= 9'(held - cycle_sum);
    end
  end

endmodule

// File: rtl/core/calendar_date_counter.sv
// Gregorian date counter.
// The block holds a date and applies one command per word on the command
// channel (cmd_valid / cmd_stall): load a date, step one day forward or back,
// or add or subtract day_count days. Every command returns one word on the
// result channel (res_valid / res_stall) carrying the date after the command
// and two flags: load_rejected for a load with an impossible month or day,
// and year_wrapped when the year ran past either end of its range.
// A load passes through the reciprocal-multiply unit that finds the year's
// place in the 400-year leap cycle. A day step is a walk of one day, with an
// added month step when it crosses into another month. Add and subtract walk one
// month per cycle through a shared month-step unit. Other action codes return
// the date unchanged.
// One command is in progress at a time; cmd_stall stays high until it is done.
// The result waits in an output register; while the receiver holds res_stall
// high, a finished command waits for the register to free and no new command
// is taken. Reset sets the date to 1 January of year 1 and empties the output.
module calendar_date_counter import cdc_pkg::*; #(
  parameter int YEAR_BITS  = 14,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  logic [2:0]            action,
  input  logic [4:0]            load_day,
  input  logic [3:0]            load_month,
  input  logic [YEAR_BITS-1:0]  load_year,
  input  logic [COUNT_BITS-1:0] day_count,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [4:0]            cur_day,
  output logic [3:0]            cur_month,
  output logic [YEAR_BITS-1:0]  cur_year,
  output logic                  load_rejected,
  output logic                  year_wrapped
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};
  localparam logic [8:0] YEAR_MAX_MOD = 9'(((2 ** YEAR_BITS) - 1) % 400);

  logic [1:0]            state;
  logic [1:0]            state_next;

  // Date state and the year's place in the leap cycle.
  logic [4:0]            day;
  logic [3:0]            month;
  logic [YEAR_BITS-1:0]  year;
  logic [8:0]            y400;

  // Command held for the duration of the work.
  logic [2:0]            act;
  logic [4:0]            ld_day;
  logic [3:0]            ld_month;
  logic [YEAR_BITS-1:0]  ld_year;
  logic [COUNT_BITS-1:0] remaining;
  logic                  rejected;
  logic                  wrapped;

  logic                  accept;
  logic                  out_free;
  logic                  rem_start;
  logic                  rem_done;
  logic [8:0]            rem;

  logic                  leap_cur;
  logic [4:0]            len_cur;
  logic [3:0]            prev_month;
  logic [4:0]            len_prev;
  logic [5:0]            rest;
  logic [YEAR_BITS-1:0]  year_fwd;
  logic [8:0]            y400_fwd;
  logic                  wrap_fwd;
  logic [YEAR_BITS-1:0]  year_bwd;
  logic [8:0]            y400_bwd;
  logic                  wrap_bwd;
  logic                  load_ok;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != ST_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign rem_start = accept && (action == ACT_LOAD);

  // Remainder of the load year by 400, for the leap test of the load check.
  cdc_rem400 #(
    .YEAR_BITS(YEAR_BITS)
  ) u_rem400 (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .value (load_year),
    .done  (rem_done),
    .rem   (rem)
  );

  // Month-step unit: month lengths and the year moved one either way.
  always_comb begin
    leap_cur   = is_leap(y400);
    len_cur    = month_len(month, leap_cur);
    prev_month = (month <= MONTH_JAN) ? MONTH_DEC : month - 4'd1;
    len_prev   = month_len(prev_month, leap_cur);
    rest       = 6'({1'b0, len_cur} - {1'b0, day} + 6'd1);

    if (year == YEAR_MAX) begin
      year_fwd = '0;
      y400_fwd = '0;
      wrap_fwd = 1'b1;
    end else begin
      year_fwd = year + YEAR_BITS'(1);
      y400_fwd = (y400 == CYCLE_LAST) ? 9'd0 : y400 + 9'd1;
      wrap_fwd = 1'b0;
    end

    if (year == '0) begin
      year_bwd = YEAR_MAX;
      y400_bwd = YEAR_MAX_MOD;
      wrap_bwd = 1'b1;
    end else begin
      year_bwd = year - YEAR_BITS'(1);
      y400_bwd = (y400 == 9'd0) ? CYCLE_LAST : y400 - 9'd1;
      wrap_bwd = 1'b0;
    end

    load_ok = (ld_month >= MONTH_JAN) && (ld_month <= MONTH_DEC) && (ld_day != 5'd0) &&
              (ld_day <= month_len(ld_month, is_leap(rem)));
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_LOAD) begin
            state_next = ST_MOD;
          end else if ((action == ACT_NEXT) || (action == ACT_PREV) ||
                       (action == ACT_ADD) || (action == ACT_SUB)) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MOD: begin
        if (rem_done) begin
          state_next = ST_FIN;
        end
      end
      ST_WALK: begin
        if (act == ACT_SUB || act == ACT_PREV) begin
          if (remaining < COUNT_BITS'(day)) begin
            state_next = ST_FIN;
          end
        end else if (remaining < COUNT_BITS'(rest)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Date registers: load commit, and per walking cycle one month step or the final move within a month.
  always_ff @(posedge clk) begin
    if (rst) begin
      day      <= 5'd1;
      month    <= MONTH_JAN;
      year     <= YEAR_BITS'(1);
      y400     <= 9'd1;
      rejected <= 1'b0;
      wrapped  <= 1'b0;
    end else begin
      if (accept) begin
        rejected <= 1'b0;
        wrapped  <= 1'b0;
      end
      if ((state == ST_MOD) && rem_done) begin
        if (load_ok) begin
          day   <= ld_day;
          month <= ld_month;
          year  <= ld_year;
          y400  <= rem;
        end else begin
          rejected <= 1'b1;
        end
      end
      if (state == ST_WALK) begin
        if (act == ACT_SUB || act == ACT_PREV) begin
          if (remaining >= COUNT_BITS'(day)) begin
            day   <= len_prev;
            month <= prev_month;
            if (month == MONTH_JAN) begin
              year <= year_bwd;
              y400 <= y400_bwd;
              if (wrap_bwd) begin
                wrapped <= 1'b1;
              end
            end
          end else begin
            day <= day - remaining[4:0];
          end
        end else begin
          if (remaining >= COUNT_BITS'(rest)) begin
            day <= 5'd1;
            if (month >= MONTH_DEC) begin
              month <= MONTH_JAN;
              year  <= year_fwd;
              y400  <= y400_fwd;
              if (wrap_fwd) begin
                wrapped <= 1'b1;
              end
            end else begin
              month <= month + 4'd1;
            end
          end else begin
            day <= day + remaining[4:0];
          end
        end
      end
    end
  end

  // Command capture and the count of days still to walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= action;
      ld_day   <= load_day;
      ld_month <= load_month;
      ld_year  <= load_year;
      if (action == ACT_NEXT || action == ACT_PREV) begin
        remaining <= COUNT_BITS'(1);
      end else begin
        remaining <= day_count;
      end
    end else if (state == ST_WALK) begin
      if (act == ACT_SUB || act == ACT_PREV) begin
        if (remaining >= COUNT_BITS'(day)) begin
          remaining <= remaining - COUNT_BITS'(day);
        end
      end else if (remaining >= COUNT_BITS'(rest)) begin
        remaining <= remaining - COUNT_BITS'(rest);
      end
    end
  end

  // Output register: holds the result word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      cur_day       <= day;
      cur_month     <= month;
      cur_year      <= year;
      load_rejected <= rejected;
      year_wrapped  <= wrapped;
    end
  end

endmodule

// File: dv/calendar_date_counter_tb.sv
`timescale 1ns / 100ps

module calendar_date_counter_tb import cdc_pkg::*; ();

  localparam int YEAR_BITS  = 14;
  localparam int COUNT_BITS = 16;
  localparam int unsigned YEAR_TOP = (1 << YEAR_BITS) - 1;
  localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;
  localparam int unsigned YEAR_SPAN_TOP = 9999;
  localparam realtime CLK_PERIOD = 12ns;
  localparam longint unsigned TIMEOUT_CYCLES = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PRINT_CAP = 40;

  // Action codes that the block treats as no operation.
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [4:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic                 rejected;
    logic                 wrapped;
  } date_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_stall;
  logic [2:0]            action;
  logic [4:0]            load_day;
  logic [3:0]            load_month;
  logic [YEAR_BITS-1:0]  load_year;
  logic [COUNT_BITS-1:0] day_count;
  logic                  res_valid;
  logic                  res_stall;
  logic [4:0]            cur_day;
  logic [3:0]            cur_month;
  logic [YEAR_BITS-1:0]  cur_year;
  logic                  load_rejected;
  logic                  year_wrapped;

  // Shadow copy of the calendar held by the block.
  int unsigned shadow_day;
  int unsigned shadow_month;
  int unsigned shadow_year;

  date_word_t  expected_dates[$];
  int unsigned err_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned n_commands;
  int unsigned n_loads;
  int unsigned n_rejected;
  int unsigned n_steps;
  int unsigned n_walks;
  int unsigned n_wraps;
  int unsigned n_checked;

  calendar_date_counter #(
    .YEAR_BITS (YEAR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .action       (action),
    .load_day     (load_day),
    .load_month   (load_month),
    .load_year    (load_year),
    .day_count    (day_count),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .cur_day      (cur_day),
    .cur_month    (cur_month),
    .cur_year     (cur_year),
    .load_rejected(load_rejected),
    .year_wrapped (year_wrapped)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Length of a month under the Gregorian leap rule.
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    bit leap;
    leap = (y % 4 == 0) && ((y % CENTURY_1 != 0) || (y % CYCLE_YEARS == 0));
    if (m == MONTH_FEB) return leap ? 32'(LEN_FEB_LEAP) : 32'(LEN_FEB);
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
      return 32'(LEN_SHORT);
    return 32'(LEN_LONG);
  endfunction

  function automatic void month_up(inout bit wrap);
    shadow_month++;
    if (shadow_month > MONTH_DEC) begin
      shadow_month = 32'(MONTH_JAN);
      if (shadow_year == YEAR_TOP) begin
        shadow_year = 0;
        wrap = 1'b1;
      end else begin
        shadow_year++;
      end
    end
  endfunction

  function automatic void month_down(inout bit wrap);
    if (shadow_month <= MONTH_JAN) begin
      shadow_month = 32'(MONTH_DEC);
      if (shadow_year == 0) begin
        shadow_year = YEAR_TOP;
        wrap = 1'b1;
      end else begin
        shadow_year--;
      end
    end else begin
      shadow_month--;
    end
  endfunction

  // Moves the shadow date forward a month at a time, then by the remainder.
  function automatic void walk_forward(input int unsigned n, inout bit wrap);
    int unsigned rest;
    while (n > 0) begin
      rest = month_days(shadow_month, shadow_year) - shadow_day + 1;
      if (n >= rest) begin
        n -= rest;
        shadow_day = 1;
        month_up(wrap);
      end else begin
        shadow_day += n;
        n = 0;
      end
    end
  endfunction

  // Moves the shadow date back, removing exactly n days.
  function automatic void walk_backward(input int unsigned n, inout bit wrap);
    while (n >= shadow_day) begin
      n -= shadow_day;
      month_down(wrap);
      shadow_day = month_days(shadow_month, shadow_year);
    end
    shadow_day -= n;
  endfunction

  // Applies one command to the shadow date and returns the word it should produce.
  function automatic date_word_t apply_date_command(input logic [2:0] act,
                                                    input int unsigned ld,
                                                    input int unsigned lm,
                                                    input int unsigned ly,
                                                    input int unsigned cnt);
    date_word_t res;
    bit rej;
    bit wrap;
    rej = 1'b0;
    wrap = 1'b0;
    case (act)
      ACT_LOAD: begin
        n_loads++;
        if (lm < MONTH_JAN || lm > MONTH_DEC || ld < 1 || ld > month_days(lm, ly)) begin
          rej = 1'b1;
          n_rejected++;
        end else begin
          shadow_day = ld;
          shadow_month = lm;
          shadow_year = ly;
        end
      end
      ACT_NEXT: begin
        n_steps++;
        walk_forward(1, wrap);
      end
      ACT_PREV: begin
        n_steps++;
        walk_backward(1, wrap);
      end
      ACT_ADD: begin
        n_walks++;
        walk_forward(cnt, wrap);
      end
      ACT_SUB: begin
        n_walks++;
        walk_backward(cnt, wrap);
      end
      default: ;
    endcase
    if (wrap) n_wraps++;
    res.day = shadow_day[4:0];
    res.month = shadow_month[3:0];
    res.year = shadow_year[YEAR_BITS-1:0];
    res.rejected = rej;
    res.wrapped = wrap;
    return res;
  endfunction

  task automatic report_error(input string msg);
    if (err_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Offers one command word, waits for it to be taken and records the expected result.
  task automatic send_command(input logic [2:0] act, input int unsigned ld,
                              input int unsigned lm, input int unsigned ly,
                              input int unsigned cnt);
    date_word_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    action     <= act;
    load_day   <= ld[4:0];
    load_month <= lm[3:0];
    load_year  <= ly[YEAR_BITS-1:0];
    day_count  <= cnt[COUNT_BITS-1:0];
    do @(posedge clk); while (cmd_stall);
    n_commands++;
    want = apply_date_command(act, 32'(ld[4:0]), 32'(lm[3:0]),
                              32'(ly[YEAR_BITS-1:0]), 32'(cnt[COUNT_BITS-1:0]));
    expected_dates.insert(expected_dates.size(), want);
  endtask

  // Holds the command side quiet until every outstanding result has arrived.
  task automatic wait_for_results;
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_dates.size() != 0);
  endtask

  // Receiver back-pressure at the rate set by the current phase.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Each result word taken is compared with the oldest expected date.
  always @(posedge clk) begin
    date_word_t want;
    if (!rst && res_valid && !res_stall) begin
      n_checked++;
      if (expected_dates.size() == 0) begin
        report_error($sformatf("result word %0d/%0d/%0d with no command outstanding",
                               cur_day, cur_month, cur_year));
      end else begin
        want = expected_dates.pop_front();
        if (cur_day !== want.day)
          report_error($sformatf("cur_day got %0d expected %0d", cur_day, want.day));
        if (cur_month !== want.month)
          report_error($sformatf("cur_month got %0d expected %0d", cur_month, want.month));
        if (cur_year !== want.year)
          report_error($sformatf("cur_year got %0d expected %0d", cur_year, want.year));
        if (load_rejected !== want.rejected)
          report_error($sformatf("load_rejected got %b expected %b",
                                 load_rejected, want.rejected));
        if (year_wrapped !== want.wrapped)
          report_error($sformatf("year_wrapped got %b expected %b",
                                 year_wrapped, want.wrapped));
      end
    end
  end

  // Load validation: month and day limits and the leap-year rule.
  task automatic test_load_checks;
    send_command(ACT_LOAD, 1, MONTH_JAN, 0, 0);
    send_command(ACT_LOAD, 31, MONTH_DEC, YEAR_SPAN_TOP, 0);
    send_command(ACT_LOAD, 29, MONTH_FEB, 2000, 0);
    send_command(ACT_LOAD, 29, MONTH_FEB, 1900, 0);
    send_command(ACT_LOAD, 29, MONTH_FEB, 2023, 0);
    send_command(ACT_LOAD, 1, 0, 2023, 0);
    send_command(ACT_LOAD, 1, 13, 2023, 0);
    send_command(ACT_LOAD, 31, 15, 2023, 0);
    send_command(ACT_LOAD, 0, 5, 2023, 0);
    send_command(ACT_LOAD, 31, MONTH_APR, 2023, 0);
  endtask

  // Single-day steps across a year end, a leap February and both ends of the year range.
  task automatic test_day_steps;
    send_command(ACT_LOAD, 31, MONTH_DEC, 2023, 0);
    send_command(ACT_NEXT, 0, 0, 0, 0);
    send_command(ACT_PREV, 0, 0, 0, 0);
    send_command(ACT_LOAD, 1, 3, 2000, 0);
    send_command(ACT_PREV, 0, 0, 0, 0);
    send_command(ACT_LOAD, 1, MONTH_JAN, 0, 0);
    send_command(ACT_PREV, 0, 0, 0, 0);
    send_command(ACT_NEXT, 0, 0, 0, 0);
  endtask

  // Day-count walks: zero counts, the largest count both ways with wraps, spare codes.
  task automatic test_day_walks;
    logic [2:0] spare;
    send_command(ACT_ADD, 0, 0, 0, 0);
    send_command(ACT_SUB, 0, 0, 0, 0);
    send_command(ACT_ADD, 0, 0, 0, COUNT_TOP);
    send_command(ACT_SUB, 0, 0, 0, COUNT_TOP);
    send_command(ACT_LOAD, 15, MONTH_JUN, 3, 0);
    send_command(ACT_SUB, 0, 0, 0, COUNT_TOP);
    send_command(ACT_ADD, 0, 0, 0, COUNT_TOP);
    for (spare = ACT_SPARE_FIRST; spare != ACT_SPARE_FIRST - 1; spare++) begin
      send_command(spare, 31, 15, YEAR_TOP, COUNT_TOP);
      if (spare == ACT_SPARE_LAST) break;
    end
  endtask

  // Random mix of loads, steps and walks; most loads are valid, the rest act as noise.
  task automatic test_random_commands(input int unsigned n_items,
                                      input int unsigned send_pct,
                                      input int unsigned recv_pct);
    logic [2:0] act;
    int unsigned ld;
    int unsigned lm;
    int unsigned ly;
    int unsigned cnt;
    int unsigned pick;
    int unsigned len;
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    repeat (n_items) begin
      pick = $urandom_range(99);
      ld = $urandom_range(31);
      lm = $urandom_range(15);
      ly = $urandom_range(YEAR_SPAN_TOP);
      pick = $urandom_range(99);
      if (pick < 4) cnt = $urandom_range(COUNT_TOP);
      else if (pick < 30) cnt = $urandom_range(1500);
      else cnt = $urandom_range(60);
      pick = $urandom_range(99);
      if (pick < 18) begin
        act = ACT_LOAD;
        if ($urandom_range(4) != 0) begin
          lm = $urandom_range(MONTH_DEC, MONTH_JAN);
          case ($urandom_range(3))
            0: ly = $urandom_range(99) * 100;
            1: ly = $urandom_range(3);
            default: ;
          endcase
          len = month_days(lm, ly);
          ld = $urandom_range(1) ? len : $urandom_range(len, 1);
        end
      end else if (pick < 36) begin
        act = ACT_NEXT;
      end else if (pick < 54) begin
        act = ACT_PREV;
      end else if (pick < 77) begin
        act = ACT_ADD;
      end else begin
        act = ACT_SUB;
      end
      send_command(act, ld, lm, ly, cnt);
    end
  endtask

  // Stimulus sequence, drain and final verdict.
  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    action = ACT_LOAD;
    load_day = '0;
    load_month = '0;
    load_year = '0;
    day_count = '0;
    err_count = 0;
    n_commands = 0;
    n_loads = 0;
    n_rejected = 0;
    n_steps = 0;
    n_walks = 0;
    n_wraps = 0;
    n_checked = 0;
    shadow_day = 1;
    shadow_month = 32'(MONTH_JAN);
    shadow_year = 1;
    sender_idle_pct = 10;
    receiver_idle_pct = 45;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_load_checks();
    test_day_steps();
    test_day_walks();
    wait_for_results();
    test_random_commands(80, 10, 45);
    wait_for_results();
    test_random_commands(80, 45, 10);
    wait_for_results();
    test_random_commands(80, 0, 0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_dates.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_dates.size()));
    $display("Covered %0d commands: %0d loads (%0d rejected), %0d day steps, %0d walks.",
             n_commands, n_loads, n_rejected, n_steps, n_walks);
    $display("Year wrapped on %0d commands; %0d result words checked.", n_wraps, n_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TIMEOUT: %0d results still outstanding", expected_dates.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
